// ----- rtl/bpa_pkg.sv -----
// ----------------------------------------------------------------------------
// Buddy page allocator package
// Shared sizes, codes, mark memory layout and controller/datapath types.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int POOL_PAGES   = 4096;
  localparam int MAX_ORDER    = 10;
  localparam int USABLE_PAGES = (POOL_PAGES >> MAX_ORDER) << MAX_ORDER;
  localparam int TOP_BLOCKS   = POOL_PAGES >> MAX_ORDER;

  localparam int ADDR_W  = 48;
  localparam int COUNT_W = 11;
  localparam int SHIFT_W = 5;
  localparam int STAT_W  = 2;

  localparam int WORD_W = 32;
  localparam int BIT_W  = $clog2(WORD_W);
  localparam int ORD_W  = $clog2(MAX_ORDER + 1);
  localparam int IDX_W  = $clog2(USABLE_PAGES);
  localparam int SROW_W = IDX_W - BIT_W;

  function automatic int rows_in_int(input int k);
    return ((USABLE_PAGES >> k) + WORD_W - 1) >> BIT_W;
  endfunction

  function automatic int row_off_int(input int k);
    int s;
    s = 0;
    for (int j = 0; j < k; j++) begin
      s += rows_in_int(j);
    end
    return s;
  endfunction

  localparam int MEM_ROWS = row_off_int(MAX_ORDER + 1);
  localparam int ROW_W    = $clog2(MEM_ROWS);
  localparam int TOP_OFF  = row_off_int(MAX_ORDER);

  function automatic logic [ROW_W-1:0] row_off(input logic [ORD_W-1:0] k);
    int s;
    s = 0;
    for (int j = 0; j <= MAX_ORDER; j++) begin
      if (j < int'(k)) begin
        s += rows_in_int(j);
      end
    end
    return ROW_W'(s);
  endfunction

  function automatic logic [SROW_W-1:0] row_last(input logic [ORD_W-1:0] k);
    logic [SROW_W-1:0] r;
    r = '0;
    for (int j = 0; j <= MAX_ORDER; j++) begin
      if (j == int'(k)) begin
        r = SROW_W'(rows_in_int(j) - 1);
      end
    end
    return r;
  endfunction

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

  typedef enum logic {
    REG_SIZE_SHIFT = 1'b0,
    REG_BASE_PAGE  = 1'b1
  } reg_index_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_CLEAR,
    DP_LOAD,
    DP_SET_NOFREE,
    DP_SET_BAD,
    DP_SEARCH_RD,
    DP_SEARCH_NEXT,
    DP_TAKE,
    DP_SPLIT_RD,
    DP_SPLIT_WR,
    DP_ADDR_SUM,
    DP_ADDR_SHIFT,
    DP_FREE_PN,
    DP_FREE_REL,
    DP_CHK_RD,
    DP_CHK_NEXT,
    DP_MERGE_INIT,
    DP_MERGE_RD,
    DP_MERGE_WR,
    DP_PUSH
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic op_free;
    logic too_big;
    logic hit;
    logic last_row;
    logic ord_top;
    logic ord_is_need;
    logic free_bad;
    logic chk_hit;
    logic merge_up;
    logic out_busy;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_A_RD,
    S_A_EV,
    S_SPLIT_RD,
    S_SPLIT_WR,
    S_ADDR_SUM,
    S_ADDR_SHIFT,
    S_F_PN,
    S_F_REL,
    S_F_TEST,
    S_CHK_RD,
    S_CHK_EV,
    S_M_RD,
    S_M_EV,
    S_FINISH
  } state_t;

endpackage

// ----- rtl/bpa_req_if.sv -----
// ----------------------------------------------------------------------------
// Buddy page allocator request channel
// Valid/ready channel carrying one allocate or free request per beat.
// ----------------------------------------------------------------------------
interface bpa_req_if import bpa_pkg::*;;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic [COUNT_W-1:0] page_count;
  logic [ADDR_W-1:0]  address;

  modport source (output valid, opcode, page_count, address, input ready);
  modport sink (input valid, opcode, page_count, address, output ready);
endinterface

// ----- rtl/bpa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Buddy page allocator response channel
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface bpa_rsp_if import bpa_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] block_address;
  logic [STAT_W-1:0] status;

  modport source (output valid, block_address, status, input ready);
  modport sink (input valid, block_address, status, output ready);
endinterface

// ----- rtl/bpa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Buddy page allocator controller
// Sequences clearing, search, split, free checks and merges in the datapath.
// ----------------------------------------------------------------------------
module bpa_ctrl import bpa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = DP_NOP;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd = DP_CLEAR;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd        = DP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.op_free) begin
          state_next = S_F_PN;
        end else if (stat.too_big) begin
          cmd        = DP_SET_NOFREE;
          state_next = S_FINISH;
        end else begin
          state_next = S_A_RD;
        end
      end
      S_A_RD: begin
        cmd        = DP_SEARCH_RD;
        state_next = S_A_EV;
      end
      S_A_EV: begin
        if (stat.hit) begin
          cmd        = DP_TAKE;
          state_next = stat.ord_is_need ? S_ADDR_SUM : S_SPLIT_RD;
        end else if (stat.last_row && stat.ord_top) begin
          cmd        = DP_SET_NOFREE;
          state_next = S_FINISH;
        end else begin
          cmd        = DP_SEARCH_NEXT;
          state_next = S_A_RD;
        end
      end
      S_SPLIT_RD: begin
        cmd        = DP_SPLIT_RD;
        state_next = S_SPLIT_WR;
      end
      S_SPLIT_WR: begin
        cmd        = DP_SPLIT_WR;
        state_next = stat.ord_is_need ? S_ADDR_SUM : S_SPLIT_RD;
      end
      S_ADDR_SUM: begin
        cmd        = DP_ADDR_SUM;
        state_next = S_ADDR_SHIFT;
      end
      S_ADDR_SHIFT: begin
        cmd        = DP_ADDR_SHIFT;
        state_next = S_FINISH;
      end
      S_F_PN: begin
        cmd        = DP_FREE_PN;
        state_next = S_F_REL;
      end
      S_F_REL: begin
        cmd        = DP_FREE_REL;
        state_next = S_F_TEST;
      end
      S_F_TEST: begin
        if (stat.free_bad) begin
          cmd        = DP_SET_BAD;
          state_next = S_FINISH;
        end else begin
          state_next = S_CHK_RD;
        end
      end
      S_CHK_RD: begin
        cmd        = DP_CHK_RD;
        state_next = S_CHK_EV;
      end
      S_CHK_EV: begin
        if (stat.chk_hit) begin
          cmd        = DP_SET_BAD;
          state_next = S_FINISH;
        end else if (stat.ord_top) begin
          cmd        = DP_MERGE_INIT;
          state_next = S_M_RD;
        end else begin
          cmd        = DP_CHK_NEXT;
          state_next = S_CHK_RD;
        end
      end
      S_M_RD: begin
        cmd        = DP_MERGE_RD;
        state_next = S_M_EV;
      end
      S_M_EV: begin
        cmd        = DP_MERGE_WR;
        state_next = stat.merge_up ? S_M_RD : S_FINISH;
      end
      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd        = DP_PUSH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

// ----- rtl/bpa_datapath.sv -----
// ----------------------------------------------------------------------------
// Buddy page allocator datapath
// Free mark memory, order and index registers, address math, result register.
// ----------------------------------------------------------------------------
module bpa_datapath import bpa_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  logic               in_opcode,
  input  logic [COUNT_W-1:0] in_page_count,
  input  logic [ADDR_W-1:0]  in_address,
  input  logic [SHIFT_W-1:0] size_shift,
  input  logic [ADDR_W-1:0]  base_page,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ADDR_W-1:0]  out_block_address,
  output logic [STAT_W-1:0]  out_status
);

  logic [WORD_W-1:0] mem [MEM_ROWS];
  logic [WORD_W-1:0] rd_data;
  logic [ROW_W-1:0]  rd_addr;
  logic [ROW_W-1:0]  clr_row;

  logic               op;
  logic [COUNT_W-1:0] count;
  logic [ADDR_W-1:0]  address;
  logic [ORD_W-1:0]   need;
  logic [ORD_W-1:0]   ord;
  logic [SROW_W-1:0]  srow;
  logic [IDX_W-1:0]   idx;
  logic [ADDR_W-1:0]  pn;
  logic               aligned;
  logic               free_bad;
  logic               too_big;
  logic [ADDR_W-1:0]  addr_sum;
  logic [ADDR_W-1:0]  res_addr;
  status_t            res_status;

  logic [ORD_W-1:0]  need_c;
  logic              too_big_c;
  logic              rd_en;
  logic [ROW_W-1:0]  raddr;
  logic              we;
  logic [ROW_W-1:0]  waddr;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] init_row;
  logic [BIT_W-1:0]  fb;
  logic [ORD_W-1:0]  ord_dn;
  logic [IDX_W-1:0]  idx_up;
  logic [IDX_W-1:0]  idx_sh;
  logic [BIT_W-1:0]  bud_pos;
  logic              bud_bit;
  logic              ord_top;
  logic [ADDR_W:0]   diff;

  always_comb begin
    need_c = '0;
    for (int n = MAX_ORDER; n >= 0; n--) begin
      if (32'(in_page_count) <= (32'd1 << n)) begin
        need_c = ORD_W'(n);
      end
    end
    too_big_c = 32'(in_page_count) > (32'd1 << MAX_ORDER);
  end

  always_comb begin
    int rr;
    rr = int'(clr_row) - TOP_OFF;
    for (int b = 0; b < WORD_W; b++) begin
      init_row[b] = (rr >= 0) && ((rr * WORD_W + b) < TOP_BLOCKS);
    end
  end

  always_comb begin
    fb = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (rd_data[b]) begin
        fb = BIT_W'(b);
      end
    end
  end

  assign ord_top = (ord == ORD_W'(MAX_ORDER));
  assign ord_dn  = ord - ORD_W'(1);
  assign idx_up  = {idx[IDX_W-2:0], 1'b0};
  assign idx_sh  = idx >> ord;
  assign bud_pos = {idx[BIT_W-1:1], ~idx[0]};
  assign bud_bit = rd_data[bud_pos];
  assign diff    = {1'b0, pn} - {1'b0, base_page};

  always_comb begin
    rd_en = 1'b0;
    raddr = '0;
    case (cmd)
      DP_SEARCH_RD: begin
        rd_en = 1'b1;
        raddr = row_off(ord) + ROW_W'(srow);
      end
      DP_SPLIT_RD: begin
        rd_en = 1'b1;
        raddr = row_off(ord_dn) + ROW_W'(idx_up >> BIT_W);
      end
      DP_CHK_RD: begin
        rd_en = 1'b1;
        raddr = row_off(ord) + ROW_W'(idx_sh >> BIT_W);
      end
      DP_MERGE_RD: begin
        rd_en = 1'b1;
        raddr = row_off(ord) + ROW_W'(idx >> BIT_W);
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = rd_addr;
    wdata = rd_data;
    case (cmd)
      DP_CLEAR: begin
        we    = 1'b1;
        waddr = clr_row;
        wdata = init_row;
      end
      DP_TAKE: begin
        we    = 1'b1;
        wdata = rd_data & ~(WORD_W'(1) << fb);
      end
      DP_SPLIT_WR: begin
        we    = 1'b1;
        wdata = rd_data | (WORD_W'(1) << {idx[BIT_W-1:1], 1'b1});
      end
      DP_MERGE_WR: begin
        we = 1'b1;
        if (bud_bit && !ord_top) begin
          wdata = rd_data & ~((WORD_W'(1) << idx[BIT_W-1:0]) | (WORD_W'(1) << bud_pos));
        end else begin
          wdata = rd_data | (WORD_W'(1) << idx[BIT_W-1:0]);
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data <= mem[raddr];
      rd_addr <= raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_row   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd == DP_CLEAR) begin
        clr_row <= clr_row + ROW_W'(1);
      end
      if (cmd == DP_PUSH) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      DP_LOAD: begin
        op         <= in_opcode;
        count      <= in_page_count;
        address    <= in_address;
        need       <= need_c;
        ord        <= need_c;
        srow       <= '0;
        too_big    <= too_big_c;
        res_status <= ST_OK;
        res_addr   <= '0;
      end
      DP_SET_NOFREE: begin
        res_status <= ST_NO_FREE;
      end
      DP_SET_BAD: begin
        res_status <= ST_BAD_FREE;
      end
      DP_SEARCH_NEXT: begin
        if (srow == row_last(ord)) begin
          ord  <= ord + ORD_W'(1);
          srow <= '0;
        end else begin
          srow <= srow + SROW_W'(1);
        end
      end
      DP_TAKE: begin
        idx <= {srow, fb};
      end
      DP_SPLIT_RD: begin
        ord <= ord_dn;
        idx <= idx_up;
      end
      DP_ADDR_SUM: begin
        addr_sum <= base_page + (ADDR_W'(idx) << need);
      end
      DP_ADDR_SHIFT: begin
        res_addr <= addr_sum << size_shift;
      end
      DP_FREE_PN: begin
        pn      <= address >> size_shift;
        aligned <= (address & ~({ADDR_W{1'b1}} << size_shift)) == '0;
      end
      DP_FREE_REL: begin
        free_bad <= (count != COUNT_W'(1)) || !aligned || diff[ADDR_W]
                    || (diff[ADDR_W-1:0] >= ADDR_W'(USABLE_PAGES));
        idx      <= diff[IDX_W-1:0];
        ord      <= '0;
      end
      DP_CHK_NEXT: begin
        ord <= ord + ORD_W'(1);
      end
      DP_MERGE_INIT: begin
        ord <= '0;
      end
      DP_MERGE_WR: begin
        if (bud_bit && !ord_top) begin
          idx <= idx >> 1;
          ord <= ord + ORD_W'(1);
        end
      end
      DP_PUSH: begin
        out_block_address <= res_addr;
        out_status        <= res_status;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    stat.clr_last    = (clr_row == ROW_W'(MEM_ROWS - 1));
    stat.op_free     = (op == OP_FREE);
    stat.too_big     = too_big;
    stat.hit         = |rd_data;
    stat.last_row    = (srow == row_last(ord));
    stat.ord_top     = ord_top;
    stat.ord_is_need = (ord == need);
    stat.free_bad    = free_bad;
    stat.chk_hit     = rd_data[idx_sh[BIT_W-1:0]];
    stat.merge_up    = bud_bit && !ord_top;
    stat.out_busy    = out_valid && !out_ready;
  end

endmodule

// ----- rtl/buddy_page_allocator.sv -----
// ----------------------------------------------------------------------------
// Buddy page allocator
// Allocates power-of-two page blocks and frees single pages with buddy merge.
//
// Channel   Dir  Beat contents
// req       in   opcode, page_count, address
// rsp       out  block_address, status
// apb       in   shift (0x0), base_page (0x8), 64-bit data
//
// An allocate scans mark rows from the needed order upward, then splits down.
// A free checks each order for a mark over the page, then merges buddies;
// a free with bad fields ends before the checks; a free of a free page ends at its order.
// The single-port mark memory is accessed one row of 32 marks at a time.
// After reset a clearing pass writes all 258 mark rows before req.ready rises.
// One result waits in the output register; a further one holds the controller.
// ----------------------------------------------------------------------------
module buddy_page_allocator import bpa_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  bpa_req_if.sink      req,
  bpa_rsp_if.source    rsp,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);

  logic [SHIFT_W-1:0] size_shift;
  logic [ADDR_W-1:0]  base_page;
  dp_cmd_t            cmd;
  dp_stat_t           stat;
  reg_index_t         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_index_t'(paddr[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      size_shift <= SHIFT_W'(12);
      base_page  <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        REG_SIZE_SHIFT: size_shift <= pwdata[SHIFT_W-1:0];
        REG_BASE_PAGE:  base_page  <= pwdata[ADDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SIZE_SHIFT: prdata = 64'(size_shift);
      REG_BASE_PAGE:  prdata = 64'(base_page);
      default:        prdata = '0;
    endcase
  end

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  bpa_datapath u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .stat              (stat),
    .in_opcode         (req.opcode),
    .in_page_count     (req.page_count),
    .in_address        (req.address),
    .size_shift        (size_shift),
    .base_page         (base_page),
    .out_valid         (rsp.valid),
    .out_ready         (rsp.ready),
    .out_block_address (rsp.block_address),
    .out_status        (rsp.status)
  );

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buddy page allocator testbench
// Drives allocate and free requests through the request channel, keeps its
// own copy of the free marks to predict every response, and compares each
// response beat field by field. Register settings change between phases.
// ----------------------------------------------------------------------------
module testbench;
  import bpa_pkg::*;

  localparam logic [63:0] M48         = 64'hFFFF_FFFF_FFFF;
  localparam int          CYCLE_LIMIT = 10000000;
  localparam int          SETTLE      = 700;

  typedef struct {
    opcode_t           op;
    logic [COUNT_W-1:0] count;
    logic [ADDR_W-1:0]  addr;
  } request_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    status_t           status;
  } response_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  bpa_req_if req ();
  bpa_rsp_if rsp ();

  buddy_page_allocator dut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bit          free_map [0:MAX_ORDER][0:USABLE_PAGES-1];
  logic [4:0]  cur_shift;
  logic [47:0] cur_base;

  request_t  pending_requests[$];
  response_t expected_responses[$];
  int        owned_pages[$];

  int  error_count = 0;
  int  cycle_count = 0;
  int  hold_off = 0;
  bit  steady = 1'b0;
  bit  req_fire = 1'b0;

  function automatic bit mark_at(int k, int idx);
    if (idx >= (USABLE_PAGES >> k)) return 1'b0;
    return free_map[k][idx];
  endfunction

  function automatic void mark_put(int k, int idx, bit v);
    if (idx < (USABLE_PAGES >> k)) free_map[k][idx] = v;
  endfunction

  function automatic logic [47:0] page_to_addr(logic [63:0] rel);
    logic [63:0] pg;
    pg = (64'(cur_base) + rel) & M48;
    return 48'((pg << cur_shift) & M48);
  endfunction

  function automatic response_t allocate_block(logic [COUNT_W-1:0] count);
    response_t r;
    int need, found, idx, start;
    r.addr = '0;
    r.status = ST_NO_FREE;
    need = 0;
    found = -1;
    idx = 0;
    while (need <= MAX_ORDER && (1 << need) < int'(count)) need++;
    if (need > MAX_ORDER) return r;
    for (int k = need; k <= MAX_ORDER && found < 0; k++) begin
      for (int i = 0; i < (USABLE_PAGES >> k); i++) begin
        if (free_map[k][i]) begin
          found = k;
          idx = i;
          break;
        end
      end
    end
    if (found < 0) return r;
    mark_put(found, idx, 1'b0);
    for (int k = found; k > need; k--) begin
      idx = idx << 1;
      mark_put(k - 1, idx + 1, 1'b1);
    end
    start = idx << need;
    r.addr = page_to_addr(64'(start));
    r.status = ST_OK;
    if (need <= 3) begin
      for (int p = 0; p < (1 << need); p++)
        owned_pages.insert(owned_pages.size(), start + p);
    end else begin
      owned_pages.insert(owned_pages.size(), start);
      for (int p = 0; p < 3; p++)
        owned_pages.insert(owned_pages.size(),
                           start + $urandom_range(1, (1 << need) - 1));
    end
    return r;
  endfunction

  function automatic status_t release_page(logic [COUNT_W-1:0] count,
                                           logic [47:0] addr);
    logic [63:0] a, pn, rel;
    int idx;
    a = 64'(addr);
    if (count != 1) return ST_BAD_FREE;
    if (((a >> cur_shift) << cur_shift) != a) return ST_BAD_FREE;
    pn = a >> cur_shift;
    if (pn < 64'(cur_base)) return ST_BAD_FREE;
    rel = pn - 64'(cur_base);
    if (rel >= 64'(USABLE_PAGES)) return ST_BAD_FREE;
    for (int k = 0; k <= MAX_ORDER; k++)
      if (mark_at(k, int'(rel >> k))) return ST_BAD_FREE;
    idx = int'(rel);
    mark_put(0, idx, 1'b1);
    for (int k = 0; k < MAX_ORDER; k++) begin
      if (!mark_at(k, idx ^ 1)) break;
      mark_put(k, idx, 1'b0);
      mark_put(k, idx ^ 1, 1'b0);
      idx = idx >> 1;
      mark_put(k + 1, idx, 1'b1);
    end
    return ST_OK;
  endfunction

  function automatic response_t predict_response(request_t q);
    response_t r;
    if (q.op == OP_ALLOC) begin
      r = allocate_block(q.count);
    end else begin
      r.status = release_page(q.count, q.addr);
      r.addr = '0;
    end
    return r;
  endfunction

  // Request driver and acceptance tracking.
  always @(posedge clk) begin
    req_fire = req.valid && req.ready;
    if (req_fire) begin
      request_t q;
      q.op = opcode_t'(req.opcode);
      q.count = req.page_count;
      q.addr = req.address;
      expected_responses.insert(expected_responses.size(), predict_response(q));
    end
  end

  always @(negedge clk) begin
    if (!rst && (!req.valid || req_fire)) begin
      if (pending_requests.size() > 0 && (steady || $urandom_range(0, 99) >= 24)) begin
        request_t q;
        q = pending_requests.pop_front();
        req.valid <= 1'b1;
        req.opcode <= q.op;
        req.page_count <= q.count;
        req.address <= q.addr;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // Response sink with random stalls and a long hold-off on request.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= steady || $urandom_range(0, 99) >= 24;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
    if (rsp.valid && rsp.ready) begin
      if (expected_responses.size() == 0) begin
        $display("%0t: unexpected response addr=%h status=%0d", $realtime,
                 rsp.block_address, rsp.status);
        error_count++;
      end else begin
        response_t e;
        e = expected_responses.pop_front();
        if (rsp.block_address !== e.addr) begin
          $display("%0t: block_address expected %h actual %h", $realtime,
                   e.addr, rsp.block_address);
          error_count++;
        end
        if (rsp.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime,
                   e.status, rsp.status);
          error_count++;
        end
      end
    end
  end

  task automatic write_reg(reg_index_t index, logic [63:0] value);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 4'(int'(index) * 8);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (index == REG_SIZE_SHIFT) cur_shift = value[4:0];
    else cur_base = value[47:0];
  endtask

  task automatic send(opcode_t op, logic [COUNT_W-1:0] count, logic [47:0] addr);
    request_t q;
    while (pending_requests.size() >= 2) @(negedge clk);
    q.op = op;
    q.count = count;
    q.addr = addr;
    pending_requests.insert(pending_requests.size(), q);
  endtask

  task automatic send_owned_free();
    int i, rel;
    while (pending_requests.size() > 0) @(negedge clk);
    if (owned_pages.size() == 0) begin
      send(OP_FREE, 11'd1, page_to_addr(64'($urandom_range(0, USABLE_PAGES - 1))));
    end else begin
      i = $urandom_range(0, owned_pages.size() - 1);
      rel = owned_pages[i];
      owned_pages.delete(i);
      send(OP_FREE, 11'd1, page_to_addr(64'(rel)));
    end
  endtask

  task automatic drain();
    while (pending_requests.size() > 0 || req.valid || expected_responses.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic random_phase(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) send(OP_ALLOC, 11'($urandom_range(1, 4)), 48'($urandom));
        else if (pick < 92) send(OP_ALLOC, 11'($urandom_range(5, 64)), '0);
        else send(OP_ALLOC, 11'($urandom_range(0, 2047)), {$urandom, $urandom});
      end else if (pick < 90) begin
        send_owned_free();
      end else if (pick < 95) begin
        send(OP_FREE, 11'($urandom), 48'({$urandom, $urandom}));
      end else begin
        send(OP_FREE, 11'd1, page_to_addr(64'($urandom_range(0, 2 * USABLE_PAGES))));
      end
    end
  endtask

  initial begin
    req.valid = 1'b0;
    req.opcode = 1'b0;
    req.page_count = '0;
    req.address = '0;
    rsp.ready = 1'b0;
    for (int k = 0; k <= MAX_ORDER; k++)
      for (int i = 0; i < USABLE_PAGES; i++)
        free_map[k][i] = (k == MAX_ORDER && i < TOP_BLOCKS);
    cur_shift = 5'd12;
    cur_base = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_reg(REG_SIZE_SHIFT, 64'd12);
    write_reg(REG_BASE_PAGE, 64'd0);
    send(OP_ALLOC, 11'd0, '0);
    send(OP_ALLOC, 11'd1, 48'hFFFF_FFFF_FFFF);
    send(OP_ALLOC, 11'd3, '0);
    send(OP_ALLOC, 11'd1025, '0);
    send(OP_ALLOC, 11'd2047, '0);
    send(OP_FREE, 11'd0, 48'h1000);
    send(OP_FREE, 11'd2, 48'h1000);
    send(OP_FREE, 11'd1, 48'h1001);
    send(OP_FREE, 11'd1, 48'(USABLE_PAGES) << 12);
    send(OP_FREE, 11'd1, 48'hFFFF_FFFF_F000);
    send(OP_FREE, 11'd1, 48'h3000);
    send_owned_free();
    send_owned_free();
    for (int i = 0; i < TOP_BLOCKS + 1; i++) send(OP_ALLOC, 11'd1024, '0);
    send(OP_ALLOC, 11'd1, '0);
    for (int i = 0; i < 4; i++) send_owned_free();
    send(OP_ALLOC, 11'd1, '0);
    drain();

    write_reg(REG_SIZE_SHIFT, 64'd0);
    write_reg(REG_BASE_PAGE, 64'h1234_5678);
    hold_off = 400;
    random_phase(400);
    drain();

    write_reg(REG_SIZE_SHIFT, 64'd20);
    write_reg(REG_BASE_PAGE, 64'hFFFF_FFFF_FF00);
    steady = 1'b1;
    random_phase(150);
    steady = 1'b0;
    drain();
    send(OP_FREE, 11'd1, 48'h0);
    random_phase(150);
    drain();

    write_reg(REG_SIZE_SHIFT, 64'd31);
    write_reg(REG_BASE_PAGE, 64'h0000_0000_0003);
    random_phase(400);
    drain();

    write_reg(REG_SIZE_SHIFT, 64'($urandom_range(1, 19)));
    write_reg(REG_BASE_PAGE, 64'({$urandom, $urandom}) & M48);
    random_phase(400);
    drain();

    if (expected_responses.size() > 0) begin
      $display("%0t: %0d responses never arrived", $realtime, expected_responses.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
